// ----- src/vectored_interrupt_controller_64_assert.svh -----
// ----------------------------------------------------------------------------
// vectored_interrupt_controller_64 assertion macros
// checks sampled on the rising clock edge, disabled in reset
// ----------------------------------------------------------------------------
`ifndef VECTORED_INTERRUPT_CONTROLLER_64_ASSERT_SVH
`define VECTORED_INTERRUPT_CONTROLLER_64_ASSERT_SVH

// same-cycle implication
`define VIC64_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vic64 check failed");

// next-cycle implication
`define VIC64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vic64 check failed");

`endif

// ----- src/vic64_pkg.sv -----
// ----------------------------------------------------------------------------
// vic64_pkg
// shared constants, register word codes and lane structs
// ----------------------------------------------------------------------------
package vic64_pkg;

  localparam int NUM_SOURCES = 64;
  localparam int LANE_W      = 32;
  localparam int NUM_LANES   = 2;
  localparam int LANE_SEL_W  = 1;
  localparam int NUM_W       = 6;
  localparam int LANE_NUM_W  = 5;

  localparam logic [63:0] SRC_MASK = (NUM_SOURCES >= 64) ? 64'hffff_ffff_ffff_ffff :
                                     ((64'd1 << NUM_SOURCES) - 64'd1);

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // register word groups, word index shifted right by one
  localparam logic [3:0] GRP_IRQ_STATUS  = 4'd0;
  localparam logic [3:0] GRP_FIQ_STATUS  = 4'd1;
  localparam logic [3:0] GRP_RAW_STATUS  = 4'd2;
  localparam logic [3:0] GRP_SELECT      = 4'd3;
  localparam logic [3:0] GRP_ENABLE_SET  = 4'd4;
  localparam logic [3:0] GRP_ENABLE_CLR  = 4'd5;
  localparam logic [3:0] GRP_TRIGGER_SET = 4'd6;
  localparam logic [3:0] GRP_TRIGGER_CLR = 4'd7;
  localparam logic [3:0] GRP_SENSE       = 4'd8;
  localparam logic [3:0] GRP_EDGE_CLR    = 4'd11;
  localparam logic [3:0] GRP_EDGE_STATUS = 4'd12;

  localparam logic CFG_SENSE_ADDR = 1'b0;

  typedef struct packed {
    logic                  load;
    logic                  wr;
    logic [3:0]            grp;
    logic [LANE_W-1:0]     wdata;
  } lane_cmd_t;

  typedef struct packed {
    logic [LANE_W-1:0]     rdata;
    logic                  irq_any;
    logic                  fiq_any;
    logic [LANE_NUM_W-1:0] irq_num;
  } lane_res_t;

endpackage

// ----- src/vic64_in_if.sv -----
// ----------------------------------------------------------------------------
// vic64_in_if
// input channel: source sample with an optional register transaction
// ----------------------------------------------------------------------------
interface vic64_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  reg_index;
  logic [31:0] write_data;
  logic [63:0] source_levels;

  modport source (output valid, operation, reg_index, write_data, source_levels,
                  input ready);
  modport sink (input valid, operation, reg_index, write_data, source_levels,
                output ready);
endinterface

// ----- src/vic64_out_if.sv -----
// ----------------------------------------------------------------------------
// vic64_out_if
// output channel: read data, interrupt lines and pending irq number
// ----------------------------------------------------------------------------
interface vic64_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_line;
  logic        fiq_line;
  logic        irq_pending;
  logic [5:0]  irq_number;

  modport source (output valid, read_data, irq_line, fiq_line, irq_pending, irq_number,
                  input ready);
  modport sink (input valid, read_data, irq_line, fiq_line, irq_pending, irq_number,
                output ready);
endinterface

// ----- src/vic64_lane.sv -----
// ----------------------------------------------------------------------------
// vic64_lane
// state, status and lowest pending irq for one 32-source half
// ----------------------------------------------------------------------------
module vic64_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  vic64_pkg::lane_cmd_t                cmd,
  input  logic [vic64_pkg::LANE_W-1:0]        levels,
  input  logic [vic64_pkg::LANE_W-1:0]        sense,
  input  logic [vic64_pkg::LANE_W-1:0]        lane_mask,
  output vic64_pkg::lane_res_t                res
);

  logic [vic64_pkg::LANE_W-1:0] enable, enable_next;
  logic [vic64_pkg::LANE_W-1:0] fiq_sel, fiq_sel_next;
  logic [vic64_pkg::LANE_W-1:0] trig, trig_next;
  logic [vic64_pkg::LANE_W-1:0] edge_latch, edge_latch_next;
  logic [vic64_pkg::LANE_W-1:0] prev_levels;
  logic [vic64_pkg::LANE_W-1:0] wbits, lv, clr, rise;
  logic [vic64_pkg::LANE_W-1:0] raw_old, st_old, raw_new, st_new, irqv, fiqv, lowest;
  logic [vic64_pkg::LANE_NUM_W-1:0] num;

  always_comb begin
    wbits           = cmd.wdata & lane_mask;
    lv              = levels & lane_mask;
    enable_next     = enable;
    fiq_sel_next    = fiq_sel;
    trig_next       = trig;
    clr             = '0;
    if (cmd.wr) begin
      case (cmd.grp)
        vic64_pkg::GRP_SELECT:      fiq_sel_next = wbits;
        vic64_pkg::GRP_ENABLE_SET:  enable_next  = enable | wbits;
        vic64_pkg::GRP_ENABLE_CLR:  enable_next  = enable & ~wbits;
        vic64_pkg::GRP_TRIGGER_SET: trig_next    = trig | wbits;
        vic64_pkg::GRP_TRIGGER_CLR: trig_next    = trig & ~wbits;
        vic64_pkg::GRP_EDGE_CLR:    clr          = wbits;
        default: ;
      endcase
    end
    rise            = lv & ~prev_levels & ~sense;
    edge_latch_next = (edge_latch & ~clr) | rise;

    // read view: state before this transaction
    raw_old = ((prev_levels & sense) | (edge_latch & ~sense) | trig) & lane_mask;
    st_old  = raw_old & enable;
    case (cmd.grp)
      vic64_pkg::GRP_IRQ_STATUS:  res.rdata = st_old & ~fiq_sel;
      vic64_pkg::GRP_FIQ_STATUS:  res.rdata = st_old & fiq_sel;
      vic64_pkg::GRP_RAW_STATUS:  res.rdata = raw_old;
      vic64_pkg::GRP_SELECT:      res.rdata = fiq_sel;
      vic64_pkg::GRP_ENABLE_SET:  res.rdata = enable;
      vic64_pkg::GRP_TRIGGER_SET: res.rdata = trig;
      vic64_pkg::GRP_SENSE:       res.rdata = sense;
      vic64_pkg::GRP_EDGE_STATUS: res.rdata = edge_latch;
      default:                    res.rdata = '0;
    endcase

    // line view: state after this transaction
    raw_new = ((lv & sense) | (edge_latch_next & ~sense) | trig_next) & lane_mask;
    st_new  = raw_new & enable_next;
    irqv    = st_new & ~fiq_sel_next;
    fiqv    = st_new & fiq_sel_next;
    lowest  = irqv & (~irqv + vic64_pkg::LANE_W'(1));
    num     = '0;
    for (int i = 0; i < vic64_pkg::LANE_W; i++) begin
      if (lowest[i]) num = num | vic64_pkg::LANE_NUM_W'(i);
    end
    res.irq_any = |irqv;
    res.fiq_any = |fiqv;
    res.irq_num = num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= '0;
      fiq_sel     <= '0;
      trig        <= '0;
      edge_latch  <= '0;
      prev_levels <= '0;
    end else if (cmd.load) begin
      enable      <= enable_next;
      fiq_sel     <= fiq_sel_next;
      trig        <= trig_next;
      edge_latch  <= edge_latch_next;
      prev_levels <= lv;
    end
  end

endmodule

// ----- src/vic64_merge.sv -----
// ----------------------------------------------------------------------------
// vic64_merge
// combines lane results into the registered output transaction
// ----------------------------------------------------------------------------
module vic64_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic                                  is_read,
  input  logic [vic64_pkg::LANE_SEL_W-1:0]      half,
  input  vic64_pkg::lane_res_t                  res [vic64_pkg::NUM_LANES],
  vic64_out_if.source                           rsp
);

  logic                          valid;
  logic [31:0]                   read_data, read_data_next;
  logic                          irq_line, irq_line_next;
  logic                          fiq_line, fiq_line_next;
  logic [vic64_pkg::NUM_W-1:0]   irq_number, irq_number_next;

  always_comb begin
    read_data_next = is_read ? res[half].rdata : '0;
    irq_line_next  = res[0].irq_any | res[1].irq_any;
    fiq_line_next  = res[0].fiq_any | res[1].fiq_any;
    // low half wins
    if (res[0].irq_any) begin
      irq_number_next = {1'b0, res[0].irq_num};
    end else if (res[1].irq_any) begin
      irq_number_next = {1'b1, res[1].irq_num};
    end else begin
      irq_number_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data  <= read_data_next;
      irq_line   <= irq_line_next;
      fiq_line   <= fiq_line_next;
      irq_number <= irq_number_next;
    end
  end

  assign rsp.valid       = valid;
  assign rsp.read_data   = read_data;
  assign rsp.irq_line    = irq_line;
  assign rsp.fiq_line    = fiq_line;
  assign rsp.irq_pending = irq_line;
  assign rsp.irq_number  = irq_number;

endmodule

// ----- src/vectored_interrupt_controller_64.sv -----
// ----------------------------------------------------------------------------
// vectored_interrupt_controller_64
// 64-source interrupt controller, two 32-source lanes and a merge stage
// accepted input is registered straight into the output transaction
// throughput: 1 transaction per cycle while rsp.ready stays high, set by the single output register
// input stalls only while a finished result waits on a low rsp.ready
// reset: synchronous, clears all interrupt state, sense mask and output valid
// ----------------------------------------------------------------------------
`include "vectored_interrupt_controller_64_assert.svh"

module vectored_interrupt_controller_64 (
  input  logic        clk,
  input  logic        rst,
  vic64_in_if.sink    req,
  vic64_out_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]          sense;
  logic                 load;
  vic64_pkg::lane_cmd_t cmd [vic64_pkg::NUM_LANES];
  vic64_pkg::lane_res_t res [vic64_pkg::NUM_LANES];

  assign pready = 1'b1;
  assign prdata = (paddr[3] == vic64_pkg::CFG_SENSE_ADDR) ? sense : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sense <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == vic64_pkg::CFG_SENSE_ADDR)) begin
      sense <= pwdata & vic64_pkg::SRC_MASK;
    end
  end

  assign req.ready = !rsp.valid || rsp.ready;
  assign load      = req.valid && req.ready;

  for (genvar g = 0; g < vic64_pkg::NUM_LANES; g++) begin : g_lane
    assign cmd[g].load  = load;
    assign cmd[g].wr    = load && (req.operation == vic64_pkg::OP_WRITE) &&
                          (req.reg_index[0] == 1'(g));
    assign cmd[g].grp   = req.reg_index[4:1];
    assign cmd[g].wdata = req.write_data;

    vic64_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd[g]),
      .levels    (req.source_levels[g*vic64_pkg::LANE_W +: vic64_pkg::LANE_W]),
      .sense     (sense[g*vic64_pkg::LANE_W +: vic64_pkg::LANE_W]),
      .lane_mask (vic64_pkg::SRC_MASK[g*vic64_pkg::LANE_W +: vic64_pkg::LANE_W]),
      .res       (res[g])
    );
  end

  vic64_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .is_read (req.operation == vic64_pkg::OP_READ),
    .half    (req.reg_index[0]),
    .res     (res),
    .rsp     (rsp)
  );

  `VIC64_ASSERT_IMP(a_pending_matches_line, rsp.valid, rsp.irq_pending == rsp.irq_line)
  `VIC64_ASSERT_IMP(a_number_needs_line, rsp.valid && (rsp.irq_number != '0), rsp.irq_line)
  `VIC64_ASSERT_NEXT(a_no_read_zero, load && (req.operation != vic64_pkg::OP_READ), rsp.read_data == '0)
  `VIC64_ASSERT_IMP(a_stall_blocks_input, rsp.valid && !rsp.ready, !req.ready)

endmodule

// ----- tb/sv/vic64_irq_checker.sv -----
// ----------------------------------------------------------------------------
// vic64_irq_checker
// passive checker for the 64-source interrupt controller: it follows every
// accepted input transaction and every sense mask write to address 0 of the config port,
// keeps its own copy of the controller state, predicts the read data and the
// interrupt outputs, and compares them with each accepted output transaction
// ----------------------------------------------------------------------------
module vic64_irq_checker
  import vic64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vic64_in_if         req,
  vic64_out_if        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output int          failures,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        fiq_line;
    logic        irq_pending;
    logic [5:0]  irq_number;
  } irq_outputs_t;

  logic [63:0] sense_mask;
  logic [63:0] enabled;
  logic [63:0] fiq_routed;
  logic [63:0] soft_pending;
  logic [63:0] edge_latched;
  logic [63:0] last_levels;

  irq_outputs_t predicted_irq_outputs[$];

  function automatic logic [63:0] raw_status(logic [63:0] levels);
    return ((levels & sense_mask) | (edge_latched & ~sense_mask) | soft_pending) & SRC_MASK;
  endfunction

  function automatic logic [63:0] register_word(logic [3:0] grp, logic [63:0] raw);
    logic [63:0] active;
    active = raw & enabled;
    case (grp)
      GRP_IRQ_STATUS:  return active & ~fiq_routed;
      GRP_FIQ_STATUS:  return active & fiq_routed;
      GRP_RAW_STATUS:  return raw;
      GRP_SELECT:      return fiq_routed;
      GRP_ENABLE_SET:  return enabled;
      GRP_TRIGGER_SET: return soft_pending;
      GRP_SENSE:       return sense_mask;
      GRP_EDGE_STATUS: return edge_latched;
      default:         return '0;
    endcase
  endfunction

  task automatic advance_controller(input logic [1:0] op, input logic [4:0] idx,
                                    input logic [31:0] wdata, input logic [63:0] levels_in,
                                    output irq_outputs_t res);
    logic [3:0]  grp;
    logic [63:0] levels;
    logic [63:0] wbits;
    logic [63:0] hmask;
    logic [63:0] rise;
    logic [63:0] clear_bits;
    logic [63:0] active;
    logic [63:0] irqv;
    logic [63:0] fiqv;
    int          shift;
    grp        = idx[4:1];
    shift      = idx[0] ? 32 : 0;
    wbits      = ({32'b0, wdata} << shift) & SRC_MASK;
    hmask      = {32'b0, 32'hffff_ffff} << shift;
    levels     = levels_in & SRC_MASK;
    clear_bits = '0;
    res        = '0;

    if (op == OP_READ) res.read_data = 32'(register_word(grp, raw_status(last_levels)) >> shift);

    if (op == OP_WRITE) begin
      case (grp)
        GRP_SELECT:      fiq_routed = (fiq_routed & ~hmask) | wbits;
        GRP_ENABLE_SET:  enabled = enabled | wbits;
        GRP_ENABLE_CLR:  enabled = enabled & ~wbits;
        GRP_TRIGGER_SET: soft_pending = soft_pending | wbits;
        GRP_TRIGGER_CLR: soft_pending = soft_pending & ~wbits;
        GRP_EDGE_CLR:    clear_bits = wbits;
        default: ;
      endcase
    end

    // a rising edge wins over a clear in the same transaction
    rise         = levels & ~last_levels & ~sense_mask & SRC_MASK;
    edge_latched = ((edge_latched & ~clear_bits) | rise) & SRC_MASK;
    last_levels  = levels;

    active = raw_status(levels) & enabled;
    irqv   = active & ~fiq_routed;
    fiqv   = active & fiq_routed;

    res.irq_line    = (irqv != '0);
    res.fiq_line    = (fiqv != '0);
    res.irq_pending = (irqv != '0);
    for (int i = 63; i >= 0; i--) begin
      if (irqv[i]) res.irq_number = 6'(i);
    end
  endtask

  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : track
    irq_outputs_t want;
    irq_outputs_t next_out;
    if (rst) begin
      sense_mask   = '0;
      enabled      = '0;
      fiq_routed   = '0;
      soft_pending = '0;
      edge_latched = '0;
      last_levels  = '0;
      predicted_irq_outputs.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (predicted_irq_outputs.size() == 0) begin
          $display("%0t: output transaction with none expected, actual read_data %h irq %b fiq %b",
                   $time, rsp.read_data, rsp.irq_line, rsp.fiq_line);
          failures++;
        end else begin
          want = predicted_irq_outputs.pop_front();
          failures += field_mismatch("read_data", want.read_data, rsp.read_data);
          failures += field_mismatch("irq_line", 32'(want.irq_line), 32'(rsp.irq_line));
          failures += field_mismatch("fiq_line", 32'(want.fiq_line), 32'(rsp.fiq_line));
          failures += field_mismatch("irq_pending", 32'(want.irq_pending), 32'(rsp.irq_pending));
          failures += field_mismatch("irq_number", 32'(want.irq_number), 32'(rsp.irq_number));
        end
      end

      if (psel && penable && pwrite && pready && paddr == {CFG_SENSE_ADDR, 3'b000})
        sense_mask = pwdata & SRC_MASK;

      if (req.valid && req.ready) begin
        advance_controller(req.operation, req.reg_index, req.write_data, req.source_levels,
                           next_out);
        predicted_irq_outputs.push_back(next_out);
      end
    end
    outstanding = predicted_irq_outputs.size();
  end

endmodule

// ----- tb/sv/tb_vectored_interrupt_controller_64.sv -----
// ----------------------------------------------------------------------------
// tb_vectored_interrupt_controller_64
// stimulus and verdict for the 64-source interrupt controller: a directed
// pass over every register word, edge versus clear and stale latches, then
// random sample, write and read transactions under several sense masks,
// with random idling on both channels and one long receiver hold
// ----------------------------------------------------------------------------
module tb_vectored_interrupt_controller_64;
  import vic64_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int NUM_PHASES      = 6;
  localparam int LONG_HOLD       = 60;
  localparam int DRAIN_CYCLES    = 4;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [3:0] GRP_DUAL_EDGE = 4'd9;
  localparam logic [3:0] GRP_EVENT     = 4'd10;
  localparam logic [3:0] GRP_UNUSED_LO = 4'd13;
  localparam logic [3:0] GRP_UNUSED_HI = 4'd15;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int          failures;
  int          outstanding;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          sense_writes = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_armed = 1'b0;
  logic [63:0] cur_levels = '0;
  logic [63:0] phase_sense [NUM_PHASES];

  vic64_in_if  req_if ();
  vic64_out_if rsp_if ();

  vectored_interrupt_controller_64 dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vic64_irq_checker irq_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycle_count, outstanding);
      $display("[vectored_interrupt_controller_64] ERROR");
      $finish;
    end
  end

  // receiver: random idling plus one long hold at the start of the first no-idle phase
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [4:0] word(logic [3:0] grp, logic hi);
    return {grp, hi};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                           input logic [31:0] data, input logic [63:0] levels);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.reg_index     <= idx;
    req_if.write_data    <= data;
    req_if.source_levels <= levels;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_sense(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_SENSE_ADDR, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sense_writes++;
  endtask

  task automatic send_random_item();
    int          r;
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [31:0] data;
    logic [3:0]  grp;
    r = $urandom_range(99);
    if (r < 55) begin
      cur_levels ^= 64'd1 << $urandom_range(63);
      if ($urandom_range(1) == 1) cur_levels ^= 64'd1 << $urandom_range(63);
    end else if (r < 70) begin
      cur_levels = {$urandom, $urandom};
    end else if (r < 78) begin
      cur_levels = '0;
    end else if (r < 86) begin
      cur_levels = '1;
    end

    r = $urandom_range(99);
    if (r < 35) op = OP_SAMPLE;
    else if (r < 75) op = OP_WRITE;
    else if (r < 95) op = OP_READ;
    else op = OP_UNUSED;

    if (op == OP_WRITE && $urandom_range(4) != 0) begin
      grp = ($urandom_range(5) == 5) ? GRP_EDGE_CLR : GRP_SELECT + 4'($urandom_range(4));
      idx = word(grp, 1'($urandom_range(1)));
    end else begin
      idx = 5'($urandom_range(31));
    end

    r = $urandom_range(99);
    if (r < 40) data = 32'd1 << $urandom_range(31);
    else if (r < 65) data = $urandom;
    else if (r < 75) data = '1;
    else if (r < 85) data = '0;
    else data = $urandom & $urandom & $urandom;

    send_item(op, idx, data, cur_levels);
  endtask

  initial begin : stimulus
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_if.valid         <= 1'b0;
    req_if.operation     <= OP_SAMPLE;
    req_if.reg_index     <= '0;
    req_if.write_data    <= '0;
    req_if.source_levels <= '0;

    phase_sense[0] = '1;
    phase_sense[1] = {$urandom, $urandom};
    phase_sense[2] = '0;
    phase_sense[3] = 64'h0000_0000_ffff_ffff;
    phase_sense[4] = {$urandom, $urandom};
    phase_sense[5] = 64'hffff_ffff_0000_0000;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 17;
    rx_idle_pct = 66;
    write_sense('0);

    // all sources rise with every source edge sensed
    send_item(OP_SAMPLE, word(GRP_IRQ_STATUS, 1'b0), '0, '1);
    send_item(OP_READ, word(GRP_EDGE_STATUS, 1'b0), '0, '1);
    send_item(OP_WRITE, word(GRP_ENABLE_SET, 1'b0), '1, '1);
    send_item(OP_WRITE, word(GRP_ENABLE_SET, 1'b1), '1, '1);
    send_item(OP_READ, word(GRP_IRQ_STATUS, 1'b0), '0, '1);
    send_item(OP_READ, word(GRP_IRQ_STATUS, 1'b1), '0, '1);
    send_item(OP_WRITE, word(GRP_SELECT, 1'b0), 32'haaaa_aaaa, '1);
    send_item(OP_WRITE, word(GRP_SELECT, 1'b1), 32'h8000_0000, '1);
    send_item(OP_READ, word(GRP_FIQ_STATUS, 1'b1), '0, '1);
    send_item(OP_READ, word(GRP_SELECT, 1'b0), '0, '1);
    // clear with levels low, then a new rise together with a clear
    send_item(OP_WRITE, word(GRP_EDGE_CLR, 1'b0), '1, '0);
    send_item(OP_WRITE, word(GRP_EDGE_CLR, 1'b1), '1, '1);
    send_item(OP_READ, word(GRP_EDGE_STATUS, 1'b1), '0, '1);
    send_item(OP_WRITE, word(GRP_EDGE_CLR, 1'b1), 32'h7fff_ffff, '1);
    send_item(OP_WRITE, word(GRP_EDGE_CLR, 1'b0), 32'hffff_fffe, '1);
    send_item(OP_WRITE, word(GRP_TRIGGER_SET, 1'b1), 32'h0000_0100, '1);
    send_item(OP_WRITE, word(GRP_ENABLE_CLR, 1'b0), '1, '1);
    send_item(OP_READ, word(GRP_TRIGGER_SET, 1'b1), '0, '1);
    send_item(OP_READ, word(GRP_ENABLE_SET, 1'b0), '0, '1);
    send_item(OP_READ, word(GRP_ENABLE_CLR, 1'b1), '0, '1);
    send_item(OP_WRITE, word(GRP_TRIGGER_CLR, 1'b1), '1, '1);
    send_item(OP_WRITE, word(GRP_SENSE, 1'b0), '1, '1);
    send_item(OP_READ, word(GRP_SENSE, 1'b1), '0, '1);
    send_item(OP_WRITE, word(GRP_DUAL_EDGE, 1'b0), '1, '1);
    send_item(OP_READ, word(GRP_EVENT, 1'b1), '0, '1);
    send_item(OP_WRITE, word(GRP_RAW_STATUS, 1'b0), '1, '1);
    send_item(OP_UNUSED, word(GRP_UNUSED_HI, 1'b1), '1, '1);
    send_item(OP_READ, word(GRP_UNUSED_LO, 1'b0), '0, '1);

    // latches kept while their sources turn level sensed
    wait_drained();
    write_sense('1);
    send_item(OP_READ, word(GRP_EDGE_STATUS, 1'b0), '0, '0);
    send_item(OP_READ, word(GRP_RAW_STATUS, 1'b0), '0, '0);
    send_item(OP_READ, word(GRP_RAW_STATUS, 1'b1), '0, '0);
    cur_levels = '0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      if (phase < 2) begin
        tx_idle_pct = 17;
        rx_idle_pct = 66;
      end else if (phase < 4) begin
        tx_idle_pct = 66;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_sense(phase_sense[phase]);
      if (phase == 4) hold_armed = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions: sample, write and read of every register word, %0d sense",
             items_sent, sense_writes);
    $display("mask settings, edge versus clear, stale latches, idling and a %0d-cycle output hold",
             LONG_HOLD);
    if (failures == 0) begin
      $display("[vectored_interrupt_controller_64] OK");
    end else begin
      $display("%0d mismatches", failures);
      $display("[vectored_interrupt_controller_64] ERROR");
    end
    $finish;
  end

endmodule
